@@ hw/rtl/sbp_pkg.sv @@
// Shared types and constants for the servo-bus packet parser.
package sbp_pkg;

  localparam int MAX_PARAMS_DEFAULT = 32;
  localparam int BYTE_W             = 8;
  localparam int COUNT_W            = 6;
  localparam int INDEX_W            = 5;

  localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] LEN_BIAS = 8'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld_id;     // take the id byte, start the running sum
    logic ld_len;    // take the length byte, derive the parameter count
    logic ld_cmd;    // take the instruction byte, clear the index
    logic ld_param;  // store one parameter byte and advance the index
    logic clr_idx;   // rewind the index (start or end of a result run)
    logic adv_idx;   // step to the next stored parameter
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic hdr_ok;    // incoming byte is a header byte
    logic more;      // more parameter bytes are expected
    logic full;      // parameter buffer has no room left
    logic sum_ok;    // incoming byte matches the checksum
    logic is_last;   // result being shown is the final one of the run
  } dp_status_t;

endpackage

@@ hw/rtl/servo_bus_packet_parser.sv @@
// Top level of the servo-bus packet parser: controller, datapath and checks.
//
// Usage: received bytes enter on the input channel (rx_byte with in_valid,
// in_stall), one item per byte. The parser hunts for two 0xFF header bytes,
// then takes id, length, instruction, length-2 parameter bytes and finally a
// checksum byte, the inverse of the low byte of the sum of id, length,
// instruction and parameters. The input is never stalled while a packet is
// being parsed. A good packet yields a run of result items on the output
// channel (out_valid, out_stall), one per parameter byte, or a single item
// with zero index and value if there are none; last marks the final item.
// The run starts in the cycle after the checksum byte and gives one item per
// cycle while the receiver does not stall; the parameter buffer's single
// read port sets that pace. During the run in_stall is high. A stalled
// receiver holds the current item steady and simply lengthens the run. Bad
// checksums and packets longer than the buffer are dropped with no result.
// Reset is synchronous: it returns the parser to the header hunt at once,
// and the buffer needs no clearing since only bytes of the current packet
// are read.
module servo_bus_packet_parser #(
  parameter int MAX_PARAMS = sbp_pkg::MAX_PARAMS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sbp_pkg::BYTE_W-1:0]    rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sbp_pkg::BYTE_W-1:0]    device_id,
  output logic [sbp_pkg::BYTE_W-1:0]    command,
  output logic [sbp_pkg::COUNT_W-1:0]   param_count,
  output logic [sbp_pkg::INDEX_W-1:0]   param_index,
  output logic [sbp_pkg::BYTE_W-1:0]    param_value,
  output logic                          last
);

  sbp_pkg::dp_cmd_t    cmd;
  sbp_pkg::dp_status_t status;

  // The controller sequences the byte phases and the result run.
  sbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the packet fields, checksum and parameter buffer.
  sbp_datapath #(
    .MAX_PARAMS(MAX_PARAMS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .rx_byte    (rx_byte),
    .cmd        (cmd),
    .status     (status),
    .device_id  (device_id),
    .command    (command),
    .param_count(param_count),
    .param_index(param_index),
    .param_value(param_value),
    .last       (last)
  );

  // No byte is taken while a result run is in progress.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input accepted during a result run");

  // A run always begins at index zero.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (param_index == '0))
    else $error("result run did not start at index zero");

  // Within a run, each taken non-final item is followed by the next index.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=>
      out_valid && (param_index == sbp_pkg::INDEX_W'($past(param_index) + 1'b1)))
    else $error("result run skipped or repeated an index");

  // Once the final item is taken the run is over.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> !out_valid)
    else $error("result run continued past its final item");

endmodule

@@ hw/rtl/sbp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/sbp_ctrl.sv @@
// Controller state machine for the servo-bus packet parser.
module sbp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  sbp_pkg::dp_status_t  status,
  output sbp_pkg::dp_cmd_t     cmd
);

  localparam logic [2:0] S_HDR0  = 3'd0;
  localparam logic [2:0] S_HDR1  = 3'd1;
  localparam logic [2:0] S_ID    = 3'd2;
  localparam logic [2:0] S_LEN   = 3'd3;
  localparam logic [2:0] S_CMD   = 3'd4;
  localparam logic [2:0] S_PARAM = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       acc;

  assign in_stall  = (state == S_EMIT);
  assign out_valid = (state == S_EMIT);
  assign acc       = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_HDR0: begin
        if (acc) begin
          state_next = status.hdr_ok ? S_HDR1 : S_HDR0;
        end
      end
      S_HDR1: begin
        if (acc) begin
          state_next = status.hdr_ok ? S_ID : S_HDR0;
        end
      end
      S_ID: begin
        if (acc) begin
          cmd.ld_id  = 1'b1;
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        if (acc) begin
          cmd.ld_len = 1'b1;
          state_next = S_CMD;
        end
      end
      S_CMD: begin
        if (acc) begin
          cmd.ld_cmd = 1'b1;
          state_next = S_PARAM;
        end
      end
      S_PARAM: begin
        if (acc) begin
          if (status.more) begin
            if (status.full) begin
              state_next = S_HDR0;
            end else begin
              cmd.ld_param = 1'b1;
            end
          end else if (status.sum_ok) begin
            cmd.clr_idx = 1'b1;
            state_next  = S_EMIT;
          end else begin
            state_next = S_HDR0;
          end
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          if (status.is_last) begin
            cmd.clr_idx = 1'b1;
            state_next  = S_HDR0;
          end else begin
            cmd.adv_idx = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_HDR0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HDR0;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/sbp_datapath.sv @@
// Datapath: held packet fields, running checksum, parameter buffer and index.
module sbp_datapath #(
  parameter int MAX_PARAMS = sbp_pkg::MAX_PARAMS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [sbp_pkg::BYTE_W-1:0]    rx_byte,
  input  sbp_pkg::dp_cmd_t              cmd,
  output sbp_pkg::dp_status_t           status,
  output logic [sbp_pkg::BYTE_W-1:0]    device_id,
  output logic [sbp_pkg::BYTE_W-1:0]    command,
  output logic [sbp_pkg::COUNT_W-1:0]   param_count,
  output logic [sbp_pkg::INDEX_W-1:0]   param_index,
  output logic [sbp_pkg::BYTE_W-1:0]    param_value,
  output logic                          last
);

  localparam int CNT_W  = $clog2(MAX_PARAMS + 1);
  localparam int ADDR_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

  logic [sbp_pkg::BYTE_W-1:0] held_id;
  logic [sbp_pkg::BYTE_W-1:0] held_command;
  logic [sbp_pkg::BYTE_W-1:0] expected_count;
  logic [sbp_pkg::BYTE_W-1:0] running_sum;
  logic [CNT_W-1:0]           idx;
  logic [CNT_W-1:0]           idx_next;
  logic [ADDR_W-1:0]          rd_addr;
  logic [sbp_pkg::BYTE_W-1:0] rd_data;
  logic [31:0]                idx_wide;
  logic                       no_params;

  assign idx_wide  = 32'(idx);
  assign no_params = (expected_count == '0);

  always_comb begin
    idx_next = idx;
    if (cmd.ld_cmd || cmd.clr_idx) begin
      idx_next = '0;
    end else if (cmd.ld_param || cmd.adv_idx) begin
      idx_next = CNT_W'(idx_wide + 32'd1);
    end
  end

  // The read address follows the next index, so the registered read data holds
  // the entry at the current index whenever that index lies within the buffer.
  assign rd_addr = (32'(idx_next) < MAX_PARAMS) ? idx_next[ADDR_W-1:0] : '0;

  sbp_ram #(
    .WIDTH (sbp_pkg::BYTE_W),
    .DEPTH (MAX_PARAMS),
    .ADDR_W(ADDR_W)
  ) u_param_ram (
    .clk  (clk),
    .we   (cmd.ld_param),
    .waddr(idx[ADDR_W-1:0]),
    .wdata(rx_byte),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_id) begin
      held_id     <= rx_byte;
      running_sum <= rx_byte;
    end
    if (cmd.ld_len) begin
      expected_count <= rx_byte - sbp_pkg::LEN_BIAS;
      running_sum    <= running_sum + rx_byte;
    end
    if (cmd.ld_cmd) begin
      held_command <= rx_byte;
      running_sum  <= running_sum + rx_byte;
    end
    if (cmd.ld_param) begin
      running_sum <= running_sum + rx_byte;
    end
  end

  assign status.hdr_ok  = (rx_byte == sbp_pkg::HDR_BYTE);
  assign status.more    = (idx_wide < 32'(expected_count));
  assign status.full    = (idx_wide >= MAX_PARAMS);
  assign status.sum_ok  = (~running_sum == rx_byte);
  assign status.is_last = no_params || ((idx_wide + 32'd1) == 32'(expected_count));

  assign device_id   = held_id;
  assign command     = held_command;
  assign param_count = expected_count[sbp_pkg::COUNT_W-1:0];
  assign param_index = no_params ? '0 : idx_wide[sbp_pkg::INDEX_W-1:0];
  assign param_value = no_params ? '0 : rd_data;
  assign last        = status.is_last;

endmodule

@@ bench/tb_servo_bus_packet_parser.sv @@
// Self-checking testbench for the servo-bus packet parser with a byte-level predictor.
`timescale 1ns / 1ps

// One result item as the parser presents it on its output channel.
typedef struct packed {
  logic [7:0] device_id;
  logic [7:0] command;
  logic [5:0] param_count;
  logic [4:0] param_index;
  logic [7:0] param_value;
  logic       last;
} param_result_t;

// Tracks the parser state byte by byte and keeps the results still owed.
class packet_tracker;
  localparam int HUNT_FIRST  = 0;
  localparam int HUNT_SECOND = 1;
  localparam int TAKE_ID     = 2;
  localparam int TAKE_LEN    = 3;
  localparam int TAKE_CMD    = 4;
  localparam int TAKE_PARAMS = 5;
  localparam int BUF_DEPTH   = sbp_pkg::MAX_PARAMS_DEFAULT;

  int            phase;
  logic [7:0]    held_id;
  logic [7:0]    held_command;
  logic [7:0]    expected_count;
  logic [7:0]    running_sum;
  logic [7:0]    param_store [BUF_DEPTH];
  param_result_t pending_params [$];
  int            results_predicted;
  int            results_checked;
  int            errors;

  function new();
    phase             = HUNT_FIRST;
    held_id           = '0;
    held_command      = '0;
    expected_count    = '0;
    running_sum       = '0;
    results_predicted = 0;
    results_checked   = 0;
    errors            = 0;
  endfunction

  // Queue one result item of the current packet.
  function void push_result(logic [4:0] idx, logic [7:0] val, logic fin);
    param_result_t r;
    r.device_id   = held_id;
    r.command     = held_command;
    r.param_count = expected_count[5:0];
    r.param_index = idx;
    r.param_value = val;
    r.last        = fin;
    pending_params.push_back(r);
    results_predicted++;
  endfunction

  // Advance the parser state by one accepted byte.
  function void take_byte(logic [7:0] b);
    int k;
    if (phase == HUNT_FIRST || phase == HUNT_SECOND) begin
      phase = (b == sbp_pkg::HDR_BYTE) ? phase + 1 : HUNT_FIRST;
    end else if (phase == TAKE_ID) begin
      held_id     = b;
      running_sum = b;
      phase       = TAKE_LEN;
    end else if (phase == TAKE_LEN) begin
      expected_count = b - sbp_pkg::LEN_BIAS;
      running_sum    = running_sum + b;
      phase          = TAKE_CMD;
    end else if (phase == TAKE_CMD) begin
      held_command = b;
      running_sum  = running_sum + b;
      phase        = TAKE_PARAMS;
    end else begin
      k = phase - TAKE_PARAMS;
      if (k < expected_count) begin
        // A byte that would not fit in the buffer kills the packet.
        if (k >= BUF_DEPTH) begin
          phase = HUNT_FIRST;
        end else begin
          param_store[k] = b;
          running_sum    = running_sum + b;
          phase          = phase + 1;
        end
      end else begin
        phase = HUNT_FIRST;
        if (~running_sum == b) begin
          if (expected_count == 0) begin
            push_result('0, '0, 1'b1);
          end else begin
            for (int i = 0; i < expected_count && i < BUF_DEPTH; i++) begin
              push_result(i[4:0], param_store[i], (i + 1 == expected_count));
            end
          end
        end
      end
    end
  endfunction

  task report_mismatch(string what);
    errors++;
    if (errors <= 30) $display("mismatch: %s", what);
  endtask

  task check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("result %0d field %s got 0x%0h want 0x%0h",
                                results_checked, name, got, want));
  endtask

  // Compare one accepted result item with the oldest one owed.
  task check_result(param_result_t got);
    param_result_t want;
    if (pending_params.size() == 0) begin
      report_mismatch($sformatf("unexpected result id 0x%0h index %0d",
                                got.device_id, got.param_index));
    end else begin
      want = pending_params.pop_front();
      check_field("device_id", got.device_id, want.device_id);
      check_field("command", got.command, want.command);
      check_field("param_count", got.param_count, want.param_count);
      check_field("param_index", got.param_index, want.param_index);
      check_field("param_value", got.param_value, want.param_value);
      check_field("last", got.last, want.last);
    end
    results_checked++;
  endtask
endclass

module tb_servo_bus_packet_parser;

  // The limit is far above the slowest legal run: a few hundred bytes, random
  // sender gaps after bursts of bytes, stalled result runs and one long
  // hold-off of the receiver.
  localparam int CYCLE_LIMIT  = 300000;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_BYTES = 160;
  localparam int DRAIN_CYCLES = 40;
  localparam int BUF_DEPTH    = sbp_pkg::MAX_PARAMS_DEFAULT;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] device_id;
  logic [7:0] command;
  logic [5:0] param_count;
  logic [4:0] param_index;
  logic [7:0] param_value;
  logic       last;

  packet_tracker tracker;
  int            cycle_count;
  int            burst_left;
  int            random_bytes;
  bit            hold_req;
  int            hold_left;
  int            stall_mode;
  int            mode_left;

  servo_bus_packet_parser u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .device_id   (device_id),
    .command     (command),
    .param_count (param_count),
    .param_index (param_index),
    .param_value (param_value),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[servo_bus_packet_parser] ERROR");
      $finish;
    end
  end

  // Every result item taken at an edge is checked against the oldest one owed.
  // All inputs change by nonblocking assignment, so the values read here are
  // the ones the block saw at this edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_result('{device_id, command, param_count, param_index,
                             param_value, last});
  end

  // Receiver: it switches at random between stall patterns, from never
  // stalling to stalling most of the time. On request it holds off for a long
  // stretch so that a result run backs up into the input channel.
  initial begin
    out_stall  = 1'b0;
    hold_left  = 0;
    mode_left  = 0;
    stall_mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ~out_stall;
          default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  // Offer one byte and wait until the parser takes it. The sender works in
  // bursts; at the end of a burst it may drop valid for a random gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_byte(b);
    random_bytes++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Send a frame: two header bytes, id, length, instruction, nparams
  // parameter bytes (all equal to fill, or random when fill is negative) and
  // the checksum XORed with sum_flip. The length byte need not match nparams,
  // which is how truncated and oversized packets are built.
  task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
                            input logic [7:0] cmd, input int nparams,
                            input int fill, input logic [7:0] sum_flip);
    logic [7:0] sum;
    logic [7:0] p;
    sum = id + len + cmd;
    send_byte(sbp_pkg::HDR_BYTE);
    send_byte(sbp_pkg::HDR_BYTE);
    send_byte(id);
    send_byte(len);
    send_byte(cmd);
    for (int i = 0; i < nparams; i++) begin
      p   = (fill < 0) ? 8'($urandom) : fill[7:0];
      sum = sum + p;
      send_byte(p);
    end
    send_byte(~sum ^ sum_flip);
  endtask

  // A well-formed frame whose length matches its parameter count.
  task automatic send_good(input logic [7:0] id, input logic [7:0] cmd,
                           input int nparams, input int fill);
    send_frame(id, 8'(nparams + sbp_pkg::LEN_BIAS), cmd, nparams, fill, 8'h00);
  endtask

  // Let the sender idle until every owed result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_params.size() != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    int n;
    int loops;
    tracker      = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    rx_byte      = '0;
    hold_req     = 1'b0;
    cycle_count  = 0;
    burst_left   = 0;
    random_bytes = 0;
    loops        = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Stray bytes and a header byte followed by a non-header
    // byte both send the parser back to the hunt.
    send_byte(8'h00);
    send_byte(8'h7E);
    send_byte(sbp_pkg::HDR_BYTE);
    send_byte(8'h00);
    // Smallest packet: no parameters gives a single item with zero index.
    send_good(8'h00, 8'h00, 0, 0);
    // A third 0xFF is taken as the id, not as another header byte.
    send_good(8'hFF, 8'hFF, 1, 8'hFF);
    // Checksum mismatches in the lowest and highest bit drop the packet.
    send_frame(8'h01, 8'd4, 8'h03, 2, -1, 8'h01);
    send_frame(8'h02, 8'd3, 8'h04, 1, -1, 8'h80);
    // A buffer filled exactly to capacity.
    send_good(8'h5A, 8'hA5, BUF_DEPTH, -1);
    // A length byte below two wraps to a huge count and overflows the buffer.
    send_frame(8'h11, 8'd0, 8'h21, BUF_DEPTH + 1, -1, 8'h00);
    // Recovery after all of the above.
    send_good(8'hC3, 8'h3C, 3, -1);
    wait_drained();

    // Random part: mostly well-formed frames with random content, the rest
    // bad checksums, line noise and frames whose length byte lies. The byte
    // count covers the directed part as well.
    while (random_bytes < RANDOM_BYTES) begin
      loops++;
      if (loops == 1) begin
        // Long receiver hold-off while a long run is produced: the result
        // run backs up and the parser has to stall its input.
        hold_req = 1'b1;
        send_good(8'($urandom), 8'($urandom), 12, -1);
        send_good(8'($urandom), 8'($urandom), 4, -1);
      end else if (loops == 12) begin
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      n    = $urandom_range(0, 99);
      n    = (n < 85) ? $urandom_range(0, 5)
           : (n < 97) ? $urandom_range(6, BUF_DEPTH - 1)
                      : BUF_DEPTH;
      if (pick < 70) begin
        send_good(8'($urandom), 8'($urandom), n, -1);
      end else if (pick < 80) begin
        send_frame(8'($urandom), 8'(n + sbp_pkg::LEN_BIAS), 8'($urandom), n, -1,
                   8'(1 << $urandom_range(0, 7)));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4))
          send_byte(($urandom_range(0, 3) == 0) ? sbp_pkg::HDR_BYTE : 8'($urandom));
      end else if (pick < 96) begin
        send_frame(8'($urandom), 8'($urandom), 8'($urandom),
                   $urandom_range(0, 6), -1, 8'h00);
      end else begin
        send_frame(8'($urandom), 8'($urandom_range(BUF_DEPTH + 3, 255)),
                   8'($urandom), BUF_DEPTH + 1, -1, 8'h00);
      end
    end

    // Wind down: wait for every owed result, then watch a while for strays.
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_params.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("[servo_bus_packet_parser] OK");
    end else begin
      $display("[servo_bus_packet_parser] ERROR");
    end
    $finish;
  end

endmodule
